// ===== rtl/core/ufmf_pkg.sv =====
`timescale 1ns / 1ps

package ufmf_pkg;

    localparam int MEDIAN_SIZE_DEF = 5;

    localparam logic [7:0] HDR_BYTE = 8'hFF;

    // APB register map: register i at byte address 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_MIN_DIST  = 3'd0,
        REG_MAX_DIST  = 3'd1,
        REG_MAX_STEP  = 3'd2,
        REG_REJ_LIMIT = 3'd3,
        REG_SPREAD    = 3'd4,
        REG_TIMEOUT   = 3'd5
    } t_reg;

    localparam logic [15:0] MIN_DIST_RST  = 16'd30;
    localparam logic [15:0] MAX_DIST_RST  = 16'd4500;
    localparam logic [15:0] MAX_STEP_RST  = 16'd10;
    localparam logic [7:0]  REJ_LIMIT_RST = 8'd5;
    localparam logic [15:0] SPREAD_RST    = 16'd5;
    localparam logic [15:0] TIMEOUT_RST   = 16'd2000;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ACCEPT  = 3'd1,
        EV_CSUM    = 3'd2,
        EV_RANGE   = 3'd3,
        EV_SLEW    = 3'd4,
        EV_RESYNC  = 3'd5,
        EV_GARBAGE = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] min_distance_mm;
        logic [15:0] max_distance_mm;
        logic [15:0] max_step_mm;
        logic [7:0]  reject_limit;
        logic [15:0] resync_spread_mm;
        logic [15:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] distance_mm;
        logic        estimate_valid;
        logic        connected;
        logic [2:0]  event_res;
    } t_out_item;

endpackage

// ===== rtl/core/ufmf_cfg.sv =====
`timescale 1ns / 1ps

module ufmf_cfg import ufmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (t_reg'(reg_idx))
                REG_MIN_DIST:  n_cfg.min_distance_mm  = pwdata[15:0];
                REG_MAX_DIST:  n_cfg.max_distance_mm  = pwdata[15:0];
                REG_MAX_STEP:  n_cfg.max_step_mm      = pwdata[15:0];
                REG_REJ_LIMIT: n_cfg.reject_limit     = pwdata[7:0];
                REG_SPREAD:    n_cfg.resync_spread_mm = pwdata[15:0];
                REG_TIMEOUT:   n_cfg.timeout_ms       = pwdata[15:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(reg_idx))
            REG_MIN_DIST:  prdata = {16'd0, r_cfg.min_distance_mm};
            REG_MAX_DIST:  prdata = {16'd0, r_cfg.max_distance_mm};
            REG_MAX_STEP:  prdata = {16'd0, r_cfg.max_step_mm};
            REG_REJ_LIMIT: prdata = {24'd0, r_cfg.reject_limit};
            REG_SPREAD:    prdata = {16'd0, r_cfg.resync_spread_mm};
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ms};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance_mm  <= MIN_DIST_RST;
            r_cfg.max_distance_mm  <= MAX_DIST_RST;
            r_cfg.max_step_mm      <= MAX_STEP_RST;
            r_cfg.reject_limit     <= REJ_LIMIT_RST;
            r_cfg.resync_spread_mm <= SPREAD_RST;
            r_cfg.timeout_ms       <= TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/ufmf_median.sv =====
`timescale 1ns / 1ps

module ufmf_median import ufmf_pkg::*; #(
    parameter int SIZE = MEDIAN_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_restart,
    input  logic [15:0] i_sample,
    output logic [15:0] o_estimate,
    output logic        o_have,
    output logic [15:0] o_next_estimate,
    output logic        o_next_have
);

    localparam int PW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CW = $clog2(SIZE + 1);

    logic [15:0]   r_store [SIZE];
    logic [PW-1:0] r_wp;
    logic [CW-1:0] r_cnt;
    logic [15:0]   r_est;
    logic          r_have;

    logic [PW-1:0] wp_eff;
    logic [PW-1:0] n_wp;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] n_cnt;
    logic [15:0]   vals [SIZE];
    logic [CW-1:0] rank [SIZE];
    logic [15:0]   med;

    assign wp_eff  = i_restart ? '0 : r_wp;
    assign cnt_eff = i_restart ? '0 : r_cnt;
    assign n_cnt   = (cnt_eff == CW'(SIZE)) ? cnt_eff : cnt_eff + 1'b1;
    assign n_wp    = (wp_eff == PW'(SIZE - 1)) ? '0 : wp_eff + 1'b1;

    // store contents as they stand after this write
    always_comb begin
        for (int i = 0; i < SIZE; i++) begin
            vals[i] = (wp_eff == PW'(i)) ? i_sample : r_store[i];
        end
    end

    // rank of each live entry; equal values are ordered by slot
    always_comb begin
        for (int i = 0; i < SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < SIZE; j++) begin
                if (CW'(j) < n_cnt &&
                    (vals[j] < vals[i] || (vals[j] == vals[i] && j < i))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        med = '0;
        for (int i = 0; i < SIZE; i++) begin
            if (CW'(i) < n_cnt && rank[i] == (n_cnt >> 1)) begin
                med = vals[i];
            end
        end
    end

    assign o_estimate      = r_est;
    assign o_have          = r_have;
    assign o_next_estimate = i_push ? med : r_est;
    assign o_next_have     = i_push | r_have;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[wp_eff] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_cnt  <= '0;
            r_est  <= '0;
            r_have <= 1'b0;
        end else if (i_push) begin
            r_wp   <= n_wp;
            r_cnt  <= n_cnt;
            r_est  <= med;
            r_have <= 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SIZE))
        else $error("sample count beyond store depth");

    a_have_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have == (r_cnt != '0))
        else $error("estimate flag disagrees with sample count");

endmodule

// ===== rtl/core/ufmf_outq.sv =====
`timescale 1ns / 1ps

module ufmf_outq import ufmf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    t_out_item  r_q [2];
    logic [1:0] r_cnt;
    logic       pop;
    logic [1:0] cnt_after_pop;

    assign pop           = o_valid && !i_stall;
    assign o_valid       = (r_cnt != 2'd0);
    assign o_item        = r_q[0];
    assign o_full        = (r_cnt == 2'd2);
    assign cnt_after_pop = r_cnt - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_push && !cnt_after_pop[0]) begin
            r_q[0] <= i_data;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && cnt_after_pop[0]) begin
            r_q[1] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= cnt_after_pop + {1'b0, i_push};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("result queue overflow");

endmodule

// ===== rtl/core/ultrasonic_frame_median_filter.sv =====
`timescale 1ns / 1ps
// Ultrasonic range-frame parser with step rejection and median filter.
// Input channel (i_valid / o_stall, i_item): each transaction is either a
// received UART byte (action 0) or a one-millisecond tick (action 1).
// Output channel (o_valid / i_stall, o_item): exactly one result per input
// transaction, in order: current estimate, estimate flag, link flag, event.
// Registers are written over the APB port; the user must write them only while
// the block is idle, since the block itself does not enforce this. An accepted
// item is held in an input register and its result is then written into the
// output queue, from whose registered count o_valid is driven.
// Throughput: one item per cycle while the output queue is not full; the frame
// checks and the MEDIAN_SIZE-entry (default five) rank select are combinational.
// Receiver stall: results collect in a two-entry output queue; once it is
// full an item in the input register holds and o_stall rises, no result is lost.
// Reset (synchronous, active low): registers take their defaults, the parser
// hunts for a header, no estimate, link down, queues empty. No clearing pass.

module ultrasonic_frame_median_filter import ufmf_pkg::*; #(
    parameter int MEDIAN_SIZE = MEDIAN_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out_item             o_item,
    input  logic                  i_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      in_accept;
    logic      fire;
    logic      q_full;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_streak, n_streak;
    logic [15:0] r_rlo, n_rlo;
    logic [15:0] r_rhi, n_rhi;
    logic        r_link, n_link;
    logic [15:0] r_quiet, n_quiet;

    logic        push;
    logic        restart;
    t_event      ev;

    logic [15:0] est;
    logic        have;
    logic [15:0] next_est;
    logic        next_have;

    logic [7:0]  csum;
    logic [15:0] frame_mm;
    logic [15:0] diff;
    logic [15:0] quiet_inc;
    logic [7:0]  streak_inc;
    logic [15:0] rlo_upd;
    logic [15:0] rhi_upd;
    logic        slew;
    logic        persistent;
    logic        coherent;

    t_out_item   res;

    ufmf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register stage
    assign fire      = r_in_valid && !q_full;
    assign o_stall   = r_in_valid && q_full;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // frame checks
    assign csum       = HDR_BYTE + r_high + r_low;
    assign frame_mm   = {r_high, r_low};
    assign diff       = (frame_mm > est) ? frame_mm - est : est - frame_mm;
    assign slew       = have && (diff > cfg.max_step_mm);
    assign rlo_upd    = (r_streak == 8'd0 || frame_mm < r_rlo) ? frame_mm : r_rlo;
    assign rhi_upd    = (r_streak == 8'd0 || frame_mm > r_rhi) ? frame_mm : r_rhi;
    assign streak_inc = (r_streak == 8'hFF) ? r_streak : r_streak + 8'd1;
    assign persistent = streak_inc >= cfg.reject_limit;
    assign coherent   = (rhi_upd - rlo_upd) <= cfg.resync_spread_mm;
    assign quiet_inc  = (r_quiet == 16'hFFFF) ? r_quiet : r_quiet + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_high   = r_high;
        n_low    = r_low;
        n_streak = r_streak;
        n_rlo    = r_rlo;
        n_rhi    = r_rhi;
        n_link   = r_link;
        n_quiet  = r_quiet;
        push     = 1'b0;
        restart  = 1'b0;
        ev       = EV_NONE;
        if (fire) begin
            if (r_in_item.action) begin
                n_quiet = quiet_inc;
                if (quiet_inc > cfg.timeout_ms) begin
                    n_link = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (r_in_item.rx_byte == HDR_BYTE) begin
                            n_phase = PH_HIGH;
                        end else begin
                            ev = EV_GARBAGE;
                        end
                    end
                    PH_HIGH: begin
                        n_high  = r_in_item.rx_byte;
                        n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        n_low   = r_in_item.rx_byte;
                        n_phase = PH_SUM;
                    end
                    PH_SUM: begin
                        n_phase = PH_HUNT;
                        if (csum != r_in_item.rx_byte) begin
                            ev = EV_CSUM;
                        end else if (frame_mm < cfg.min_distance_mm ||
                                     frame_mm > cfg.max_distance_mm) begin
                            ev = EV_RANGE;
                        end else if (slew && !(persistent && coherent)) begin
                            // rejected step; a persistent but scattered run restarts
                            n_rlo    = rlo_upd;
                            n_rhi    = rhi_upd;
                            n_streak = persistent ? 8'd0 : streak_inc;
                            ev       = EV_SLEW;
                        end else begin
                            if (slew) begin
                                n_rlo = rlo_upd;
                                n_rhi = rhi_upd;
                            end
                            restart  = slew;
                            push     = 1'b1;
                            n_streak = 8'd0;
                            n_link   = 1'b1;
                            n_quiet  = 16'd0;
                            ev       = slew ? EV_RESYNC : EV_ACCEPT;
                        end
                    end
                    default: n_phase = PH_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_high   <= '0;
            r_low    <= '0;
            r_streak <= '0;
            r_rlo    <= '0;
            r_rhi    <= '0;
            r_link   <= 1'b0;
            r_quiet  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_high   <= n_high;
            r_low    <= n_low;
            r_streak <= n_streak;
            r_rlo    <= n_rlo;
            r_rhi    <= n_rhi;
            r_link   <= n_link;
            r_quiet  <= n_quiet;
        end
    end

    ufmf_median #(
        .SIZE (MEDIAN_SIZE)
    ) u_median (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_restart       (restart),
        .i_sample        (frame_mm),
        .o_estimate      (est),
        .o_have          (have),
        .o_next_estimate (next_est),
        .o_next_have     (next_have)
    );

    assign res.distance_mm    = next_est;
    assign res.estimate_valid = next_have;
    assign res.connected      = n_link;
    assign res.event_res      = ev;

    ufmf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    a_link_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_link) |-> $past(push))
        else $error("link came up without an accepted frame");

    a_push_sets_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> have)
        else $error("estimate flag not set after a sample was stored");

    a_phase_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_phase) && $stable(r_quiet))
        else $error("parser state moved without a transaction");

endmodule
